// ----- sv/rdisc_pkg.sv -----
// Package with the item types, codes and helper functions of the route discovery unit.
package rdisc_pkg;

	localparam int NODES_DEF = 16;
	localparam int PORTS_DEF = 8;
	localparam int FLOOD_MAX = 8;
	localparam logic [47:0] BCAST_MAC = 48'hffff_ffff_ffff;
	localparam logic [7:0] HOPS_MAX = 8'hff;

	typedef enum logic [1:0] {
		K_REQ = 2'd0,
		K_REP = 2'd1,
		K_DATA = 2'd2,
		K_BAD = 2'd3
	} pkt_kind_t;

	typedef enum logic [1:0] {
		O_REQ = 2'd0,
		O_REP = 2'd1,
		O_FWD = 2'd2,
		O_LOCAL = 2'd3
	} out_kind_t;

	typedef enum logic [1:0] {
		UPD_NONE = 2'd0,
		UPD_SAME = 2'd1,
		UPD_NEW = 2'd2
	} upd_t;

	typedef enum logic [1:0] {
		CFG_OWN = 2'd0,
		CFG_STALE = 2'd1,
		CFG_HOPLIM = 2'd2,
		CFG_PORTS = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0] packet_kind;
		logic [2:0] arrival_port;
		logic [47:0] sender_mac;
		logic [3:0] origin_node;
		logic [3:0] target_node;
		logic [15:0] origin_port;
		logic [15:0] target_port;
		logic [7:0] hops;
		logic [31:0] bcast_id;
		logic reply_already_sent;
		logic force_rediscovery;
		logic [31:0] now_seconds;
	} req_t;

	typedef struct packed {
		logic [1:0] out_kind;
		logic [2:0] out_port;
		logic [47:0] next_mac;
		logic [3:0] out_origin;
		logic [3:0] out_target;
		logic [15:0] out_origin_port;
		logic [15:0] out_target_port;
		logic [7:0] out_hops;
		logic [31:0] out_bcast_id;
		logic out_reply_sent;
		logic out_force;
		logic last;
	} rsp_t;

	typedef struct packed {
		logic [31:0] bcast;
		logic [2:0] port;
		logic [47:0] mac;
		logic [7:0] hops;
		logic [31:0] stamp;
	} ent_t;

	function automatic logic [7:0] inc_hops(logic [7:0] h);
		return (h == HOPS_MAX) ? HOPS_MAX : h + 8'd1;
	endfunction

endpackage

// ----- sv/rdisc_in_if.sv -----
// Input channel carrying one received routing frame per item.
interface rdisc_in_if import rdisc_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- sv/rdisc_out_if.sv -----
// Output channel carrying one emitted frame per item.
interface rdisc_out_if import rdisc_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- sv/on_demand_route_discovery_unit.sv -----
// Route discovery engine: route table memory, decision logic and result sequencing.
//
// Channel  Dir  Payload  Handshake
// in_ch    in   req_t    valid/ready, one received frame
// out_ch   out  rsp_t    valid/ready, one emitted frame, last on the final one
// cfg      in   16 bits  cfg_we with cfg_idx, no back-pressure
//
// A frame passes through accept with the origin entry read, judge with write back and
// target entry read, decide, and emit, which sends its items in turn or none at all; a
// dropped frame goes from judge back to idle. The memory read is registered.
// Reset clears the valid bits, sets the broadcast counter to 1 and loads the default configuration at once.
// A stalled output holds the sequencer; new frames are taken only when it is idle.
module on_demand_route_discovery_unit import rdisc_pkg::*; #(
	parameter int NODES = NODES_DEF,
	parameter int PORTS = PORTS_DEF
) (
	input logic clk,
	input logic arst_n,
	rdisc_in_if.sink in_ch,
	rdisc_out_if.source out_ch,
	input logic cfg_we,
	input logic [1:0] cfg_idx,
	input logic [15:0] cfg_data
);

	localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_JUDGE = 4'b0010,
		S_DEC = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	function automatic logic [IW-1:0] ent_idx(logic [3:0] n);
		logic [8:0] v;
		v = {5'b0, n};
		for (int i = 0; i < 8; i++) begin
			if (v >= 9'(NODES)) v = v - 9'(NODES);
		end
		return v[IW-1:0];
	endfunction

	state_t st_q;
	req_t in_q;
	logic [3:0] own_q;
	logic [15:0] stale_q;
	logic [7:0] hoplim_q;
	logic [3:0] pcnt_q;
	logic [31:0] bcnt_q;
	logic [NODES-1:0] vld_q;
	ent_t mem [NODES];
	ent_t rd_q;
	ent_t org_q;
	upd_t upd_q;
	logic fwd_q;
	rsp_t rep_q, fld_q;
	logic rep_pend_q;
	logic [FLOOD_MAX-1:0] mask_q;
	rsp_t out_q;
	logic out_v_q;

	logic [IW-1:0] eo, et, rd_addr;
	logic mem_we;
	ent_t new_ent, tgt;
	logic drop, oval, ostale, tstale, tpres;
	upd_t upd;
	logic out_free, out_load;
	rsp_t load;
	logic [3:0] lim;
	logic [FLOOD_MAX-1:0] fmask, low_bit;
	logic [2:0] low_port;

	assign in_ch.ready = (st_q == S_IDLE);
	assign out_ch.valid = out_v_q;
	assign out_ch.data = out_q;
	assign out_free = !out_v_q || out_ch.ready;

	assign eo = ent_idx(in_q.origin_node);
	assign et = ent_idx(in_q.target_node);
	assign rd_addr = (st_q == S_IDLE) ? ent_idx(in_ch.data.origin_node) : et;

	always_comb begin
		new_ent.bcast = in_q.bcast_id;
		new_ent.port = in_q.arrival_port;
		new_ent.mac = in_q.sender_mac;
		new_ent.hops = in_q.hops;
		new_ent.stamp = in_q.now_seconds;
		drop = (in_q.packet_kind == K_BAD) || ((in_q.packet_kind == K_REQ) &&
			((in_q.origin_node == own_q) || (in_q.hops >= hoplim_q)));
		oval = vld_q[eo];
		ostale = (in_q.now_seconds - rd_q.stamp) >= {16'b0, stale_q};
		if (!oval || ostale || in_q.force_rediscovery) upd = UPD_NEW;
		else if ((rd_q.bcast != 32'd0) && (in_q.bcast_id != 32'd0) &&
				(rd_q.bcast != in_q.bcast_id))
			upd = (rd_q.bcast < in_q.bcast_id) ? UPD_NEW : UPD_NONE;
		else if (rd_q.hops > in_q.hops) upd = UPD_NEW;
		else if (rd_q.hops == in_q.hops) upd = UPD_SAME;
		else upd = UPD_NONE;
		mem_we = (st_q == S_JUDGE) && !drop && (upd != UPD_NONE);
	end

	always_comb begin
		tgt = fwd_q ? new_ent : rd_q;
		tstale = (in_q.now_seconds - tgt.stamp) >= {16'b0, stale_q};
		tpres = vld_q[et] && !tstale;
		lim = pcnt_q;
		if (32'(lim) > PORTS) lim = 4'(PORTS);
		if (lim > 4'(FLOOD_MAX)) lim = 4'(FLOOD_MAX);
		for (int p = 0; p < FLOOD_MAX; p++) begin
			fmask[p] = (4'(p) < lim) && (3'(p) != in_q.arrival_port);
		end
		low_bit = mask_q & (~mask_q + 1'b1);
		low_port = '0;
		for (int p = FLOOD_MAX - 1; p >= 0; p--) begin
			if (mask_q[p]) low_port = 3'(p);
		end
	end

	always_comb begin
		load = fld_q;
		out_load = 1'b0;
		if (st_q == S_EMIT && out_free) begin
			if (rep_pend_q) begin
				load = rep_q;
				load.last = (mask_q == '0);
				out_load = 1'b1;
			end else if (mask_q != '0) begin
				load = fld_q;
				load.out_port = low_port;
				load.last = ((mask_q & ~low_bit) == '0);
				out_load = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[eo] <= new_ent;
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q <= '0;
			stale_q <= 16'd5;
			hoplim_q <= 8'd10;
			pcnt_q <= 4'd8;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_OWN: own_q <= cfg_data[3:0];
				CFG_STALE: stale_q <= cfg_data;
				CFG_HOPLIM: hoplim_q <= cfg_data[7:0];
				CFG_PORTS: pcnt_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) out_q <= load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			vld_q <= '0;
			bcnt_q <= 32'd1;
			rep_pend_q <= 1'b0;
			mask_q <= '0;
			upd_q <= UPD_NONE;
			fwd_q <= 1'b0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (in_ch.valid) st_q <= S_JUDGE;
				end
				S_JUDGE: begin
					if (drop) begin
						st_q <= S_IDLE;
					end else begin
						st_q <= S_DEC;
						upd_q <= upd;
						fwd_q <= (upd != UPD_NONE) && (et == eo);
						if (upd != UPD_NONE) vld_q[eo] <= 1'b1;
					end
				end
				S_DEC: begin
					rep_pend_q <= 1'b0;
					mask_q <= '0;
					st_q <= S_EMIT;
					unique case (in_q.packet_kind)
						K_REQ: begin
							if (!in_q.reply_already_sent && in_q.target_node == own_q) begin
								rep_pend_q <= (upd_q == UPD_NEW);
							end else begin
								if (!in_q.reply_already_sent) begin
									if (in_q.force_rediscovery || !tpres) vld_q[et] <= 1'b0;
									else rep_pend_q <= 1'b1;
								end
								if (upd_q != UPD_NONE) mask_q <= fmask;
							end
						end
						K_REP: begin
							if (upd_q == UPD_NEW && in_q.target_node != own_q) begin
								if (tpres) begin
									rep_pend_q <= 1'b1;
								end else begin
									vld_q[et] <= 1'b0;
									mask_q <= fmask;
									bcnt_q <= (bcnt_q == 32'hffff_ffff) ? 32'd1 : bcnt_q + 32'd1;
								end
							end
						end
						K_DATA: begin
							if (in_q.target_node == own_q || tpres) begin
								rep_pend_q <= 1'b1;
							end else begin
								vld_q[et] <= 1'b0;
								mask_q <= fmask;
								bcnt_q <= (bcnt_q == 32'hffff_ffff) ? 32'd1 : bcnt_q + 32'd1;
							end
						end
						default: st_q <= S_IDLE;
					endcase
				end
				S_EMIT: begin
					if (out_load) begin
						if (rep_pend_q) rep_pend_q <= 1'b0;
						else mask_q <= mask_q & ~low_bit;
						if (load.last) st_q <= S_IDLE;
					end else if (!rep_pend_q && mask_q == '0) begin
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) in_q <= in_ch.data;
		if (st_q == S_JUDGE) begin
			org_q <= (upd != UPD_NONE) ? new_ent : rd_q;
		end
		if (st_q == S_DEC) begin
			fld_q.out_kind <= O_REQ;
			fld_q.out_port <= '0;
			fld_q.next_mac <= BCAST_MAC;
			fld_q.out_target <= in_q.target_node;
			fld_q.out_target_port <= in_q.target_port;
			fld_q.out_force <= in_q.force_rediscovery;
			fld_q.last <= 1'b0;
			rep_q.out_force <= in_q.force_rediscovery;
			rep_q.last <= 1'b0;
			if (in_q.packet_kind == K_REQ) begin
				fld_q.out_origin <= in_q.origin_node;
				fld_q.out_origin_port <= in_q.origin_port;
				fld_q.out_hops <= inc_hops(in_q.hops);
				fld_q.out_bcast_id <= in_q.bcast_id;
				fld_q.out_reply_sent <= in_q.reply_already_sent ||
					(!in_q.force_rediscovery && tpres);
				rep_q.out_kind <= O_REP;
				rep_q.out_port <= in_q.arrival_port;
				rep_q.next_mac <= org_q.mac;
				rep_q.out_origin <= in_q.target_node;
				rep_q.out_target <= in_q.origin_node;
				rep_q.out_origin_port <= in_q.target_port;
				rep_q.out_target_port <= in_q.origin_port;
				rep_q.out_hops <= (in_q.target_node == own_q) ? 8'd1 : inc_hops(tgt.hops);
				rep_q.out_bcast_id <= '0;
				rep_q.out_reply_sent <= 1'b0;
			end else begin
				fld_q.out_origin <= own_q;
				fld_q.out_origin_port <= '0;
				fld_q.out_hops <= 8'd1;
				fld_q.out_bcast_id <= bcnt_q;
				fld_q.out_reply_sent <= 1'b0;
				rep_q.out_origin <= in_q.origin_node;
				rep_q.out_target <= in_q.target_node;
				rep_q.out_origin_port <= in_q.origin_port;
				rep_q.out_target_port <= in_q.target_port;
				rep_q.out_bcast_id <= in_q.bcast_id;
				rep_q.out_reply_sent <= in_q.reply_already_sent;
				if (in_q.packet_kind == K_DATA && in_q.target_node == own_q) begin
					rep_q.out_kind <= O_LOCAL;
					rep_q.out_port <= '0;
					rep_q.next_mac <= '0;
					rep_q.out_hops <= in_q.hops;
				end else begin
					rep_q.out_kind <= (in_q.packet_kind == K_DATA) ? O_FWD : O_REP;
					rep_q.out_port <= tgt.port;
					rep_q.next_mac <= tgt.mac;
					rep_q.out_hops <= inc_hops(in_q.hops);
				end
			end
		end
	end

	a_write_in_judge: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> st_q == S_JUDGE) else $error("route write outside judge cycle");
	a_bcnt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		bcnt_q != 32'd0) else $error("broadcast counter reached zero");
	a_accept_judge: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> st_q == S_JUDGE)
		else $error("accepted item not judged");
	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && load.last) |=> (!rep_pend_q && mask_q == '0))
		else $error("item marked last with work pending");

endmodule

// ----- dv/tb.sv -----
// Testbench for the route discovery unit: directed table, random frames, self-checking predictor.
module tb;
	import rdisc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_idx = '0;
	logic [15:0] cfg_data = '0;

	rdisc_in_if in_ch ();
	rdisc_out_if out_ch ();

	on_demand_route_discovery_unit uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	typedef struct {
		req_t req;
		int typed;
		rsp_t rsp;
	} row_t;

	// Table of routes toward each node and the unit's settings, as the unit should hold them.
	bit rt_valid [16];
	bit [31:0] rt_bcast [16];
	bit [2:0] rt_port [16];
	bit [47:0] rt_mac [16];
	bit [7:0] rt_hops [16];
	bit [31:0] rt_stamp [16];
	bit [31:0] next_id;
	bit [3:0] own_node;
	bit [15:0] stale_sec;
	bit [7:0] hop_lim;
	bit [3:0] port_cnt;

	rsp_t frames_due [$];
	rsp_t burst [$];
	int mismatches = 0;
	int frames_seen = 0;
	int frames_sent = 0;
	bit calm = 1'b0;
	bit [31:0] clock_s = 32'd1000;

	function automatic bit stale(bit [3:0] e, bit [31:0] now);
		return (now - rt_stamp[e]) >= {16'd0, stale_sec};
	endfunction

	function automatic bit [7:0] bump(bit [7:0] h);
		return (h == 8'hff) ? h : h + 8'd1;
	endfunction

	function automatic void emit(out_kind_t k, bit [2:0] p, bit [47:0] mac, bit [3:0] o,
		bit [3:0] t, bit [15:0] op, bit [15:0] tp, bit [7:0] h, bit [31:0] b, bit rs, bit f);
		rsp_t r;
		if (burst.size() >= 9) return;
		r = '{k, p, mac, o, t, op, tp, h, b, rs, f, 1'b0};
		burst.push_back(r);
	endfunction

	function automatic void flood(bit [2:0] skip, bit [3:0] o, bit [3:0] t, bit [15:0] op,
		bit [15:0] tp, bit [7:0] h, bit [31:0] b, bit rs, bit f);
		int lim;
		lim = (port_cnt > 8) ? 8 : port_cnt;
		for (int p = 0; p < lim; p++)
			if (p != skip)
				emit(O_REQ, p[2:0], BCAST_MAC, o, t, op, tp, h, b, rs, f);
	endfunction

	function automatic bit reachable(bit [3:0] n, bit [31:0] now);
		if (!rt_valid[n] || stale(n, now)) begin
			rt_valid[n] = 1'b0;
			return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic upd_t learn(req_t r);
		upd_t u;
		bit [3:0] e;
		e = r.origin_node;
		if (!rt_valid[e] || stale(e, r.now_seconds) || r.force_rediscovery)
			u = UPD_NEW;
		else if (rt_bcast[e] != 0 && r.bcast_id != 0 && rt_bcast[e] != r.bcast_id)
			u = (rt_bcast[e] < r.bcast_id) ? UPD_NEW : UPD_NONE;
		else if (rt_hops[e] > r.hops)
			u = UPD_NEW;
		else if (rt_hops[e] == r.hops)
			u = UPD_SAME;
		else
			u = UPD_NONE;
		if (u != UPD_NONE) begin
			rt_valid[e] = 1'b1;
			rt_bcast[e] = r.bcast_id;
			rt_port[e] = r.arrival_port;
			rt_mac[e] = r.sender_mac;
			rt_hops[e] = r.hops;
			rt_stamp[e] = r.now_seconds;
		end
		return u;
	endfunction

	function automatic void discover(req_t r);
		bit [31:0] b;
		b = next_id;
		next_id = (next_id == 32'hffff_ffff) ? 32'd1 : next_id + 32'd1;
		flood(r.arrival_port, own_node, r.target_node, 16'd0, r.target_port, 8'd1, b, 1'b0,
			r.force_rediscovery);
	endfunction

	function automatic void route_frame(req_t r);
		upd_t u;
		bit rs;
		bit [3:0] o, t;
		o = r.origin_node;
		t = r.target_node;
		rs = r.reply_already_sent;
		burst.delete();
		case (r.packet_kind)
			K_REQ: begin
				if (o != own_node && r.hops < hop_lim) begin
					u = learn(r);
					if (!rs && t == own_node) begin
						if (u == UPD_NEW)
							emit(O_REP, r.arrival_port, rt_mac[o], t, o, r.target_port,
								r.origin_port, 8'd1, 32'd0, 1'b0, r.force_rediscovery);
					end else begin
						if (!rs) begin
							if (r.force_rediscovery)
								rt_valid[t] = 1'b0;
							else if (reachable(t, r.now_seconds)) begin
								emit(O_REP, r.arrival_port, rt_mac[o], t, o, r.target_port,
									r.origin_port, bump(rt_hops[t]), 32'd0, 1'b0, 1'b0);
								rs = 1'b1;
							end
						end
						if (u != UPD_NONE)
							flood(r.arrival_port, o, t, r.origin_port, r.target_port,
								bump(r.hops), r.bcast_id, rs, r.force_rediscovery);
					end
				end
			end
			K_REP: begin
				u = learn(r);
				if (u == UPD_NEW && t != own_node) begin
					if (reachable(t, r.now_seconds))
						emit(O_REP, rt_port[t], rt_mac[t], o, t, r.origin_port,
							r.target_port, bump(r.hops), r.bcast_id, rs, r.force_rediscovery);
					else
						discover(r);
				end
			end
			K_DATA: begin
				void'(learn(r));
				if (t == own_node)
					emit(O_LOCAL, 3'd0, 48'd0, o, t, r.origin_port, r.target_port, r.hops,
						r.bcast_id, rs, r.force_rediscovery);
				else if (reachable(t, r.now_seconds))
					emit(O_FWD, rt_port[t], rt_mac[t], o, t, r.origin_port, r.target_port,
						bump(r.hops), r.bcast_id, rs, r.force_rediscovery);
				else
					discover(r);
			end
			default: ;
		endcase
		if (burst.size() > 0)
			burst[burst.size() - 1].last = 1'b1;
	endfunction

	function automatic req_t frame(pkt_kind_t k, bit [2:0] ap, bit [3:0] o, bit [3:0] t,
		bit [7:0] h, bit [31:0] b, bit rs, bit f, bit [31:0] now);
		req_t r;
		r.packet_kind = k;
		r.arrival_port = ap;
		r.sender_mac = 48'({$urandom, $urandom});
		r.origin_node = o;
		r.target_node = t;
		r.origin_port = 16'($urandom);
		r.target_port = 16'($urandom);
		r.hops = h;
		r.bcast_id = b;
		r.reply_already_sent = rs;
		r.force_rediscovery = f;
		r.now_seconds = now;
		return r;
	endfunction

	task automatic send(req_t r);
		if (!calm && $urandom_range(99) < 11) begin
			in_ch.valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.data = r;
		do @(posedge clk); while (!in_ch.ready);
		frames_sent++;
		@(negedge clk);
	endtask

	task automatic send_checked(req_t r);
		route_frame(r);
		foreach (burst[i]) frames_due.push_back(burst[i]);
		send(r);
	endtask

	task automatic drain();
		in_ch.valid = 1'b0;
		while (frames_due.size() != 0) @(negedge clk);
		repeat (15) @(negedge clk);
	endtask

	task automatic set_reg(cfg_idx_t i, bit [15:0] v);
		cfg_we = 1'b1;
		cfg_idx = i;
		cfg_data = v;
		@(negedge clk);
		cfg_we = 1'b0;
		case (i)
			CFG_OWN: own_node = v[3:0];
			CFG_STALE: stale_sec = v;
			CFG_HOPLIM: hop_lim = v[7:0];
			default: port_cnt = v[3:0];
		endcase
	endtask

	task automatic setup(bit [3:0] o, bit [15:0] s, bit [7:0] h, bit [3:0] p);
		set_reg(CFG_OWN, 16'(o));
		set_reg(CFG_STALE, s);
		set_reg(CFG_HOPLIM, 16'(h));
		set_reg(CFG_PORTS, 16'(p));
	endtask

	task automatic random_frames(int n);
		req_t r;
		pkt_kind_t k;
		bit [3:0] o, t;
		int pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			k = (pick < 40) ? K_REQ : (pick < 65) ? K_REP : (pick < 95) ? K_DATA : K_BAD;
			o = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(5));
			t = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(5));
			if ($urandom_range(29) == 0)
				clock_s = clock_s + $urandom;
			else
				clock_s = clock_s + $urandom_range(3);
			r = frame(k, 3'($urandom_range(7)), o, t,
				($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(6)),
				($urandom_range(4) == 0) ? 32'd0 :
				($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(1, 8)),
				$urandom_range(4) == 0, $urandom_range(7) == 0, clock_s);
			send_checked(r);
		end
	endtask

	always @(negedge clk)
		out_ch.ready <= calm || ($urandom_range(99) >= 11);

	always @(posedge clk) begin
		rsp_t want;
		if (out_ch.valid && out_ch.ready) begin
			frames_seen++;
			if (frames_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: %p", out_ch.data);
			end else begin
				want = frames_due.pop_front();
				if (out_ch.data.out_kind !== want.out_kind
						|| out_ch.data.out_port !== want.out_port
						|| out_ch.data.next_mac !== want.next_mac
						|| out_ch.data.out_origin !== want.out_origin
						|| out_ch.data.out_target !== want.out_target
						|| out_ch.data.out_origin_port !== want.out_origin_port
						|| out_ch.data.out_target_port !== want.out_target_port
						|| out_ch.data.out_hops !== want.out_hops
						|| out_ch.data.out_bcast_id !== want.out_bcast_id
						|| out_ch.data.out_reply_sent !== want.out_reply_sent
						|| out_ch.data.out_force !== want.out_force
						|| out_ch.data.last !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", want, out_ch.data);
				end
			end
		end
	end

	initial begin
		#3ms;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		row_t rows [$];
		row_t w;
		req_t q;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		foreach (rt_valid[i]) rt_valid[i] = 1'b0;
		next_id = 32'd1;
		own_node = 4'd0;
		stale_sec = 16'd5;
		hop_lim = 8'd10;
		port_cnt = 4'd8;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		q = frame(K_DATA, 3'd7, 4'd1, 4'd0, 8'd4, 32'd0, 1'b1, 1'b1, 32'd100);
		w = '{q, 1, '{O_LOCAL, 3'd0, 48'd0, 4'd1, 4'd0, q.origin_port, q.target_port,
			8'd4, 32'd0, 1'b1, 1'b1, 1'b1}};
		rows.push_back(w);
		rows.push_back('{frame(K_BAD, 3'd2, 4'd3, 4'd4, 8'd1, 32'd5, 1'b0, 1'b0, 32'd100), 0,
			rsp_t'('0)});
		rows.push_back('{frame(K_REQ, 3'd1, 4'd0, 4'd4, 8'd1, 32'd5, 1'b0, 1'b0, 32'd100), 0,
			rsp_t'('0)});
		rows.push_back('{frame(K_REQ, 3'd1, 4'd2, 4'd4, 8'd10, 32'd5, 1'b0, 1'b0, 32'd100), 0,
			rsp_t'('0)});
		rows.push_back('{frame(K_REQ, 3'd1, 4'd2, 4'd4, 8'hff, 32'd5, 1'b0, 1'b0, 32'd100), 0,
			rsp_t'('0)});
		rows.push_back('{frame(K_REQ, 3'd1, 4'd2, 4'd0, 8'd0, 32'd1, 1'b0, 1'b0, 32'd101), -1,
			rsp_t'('0)});
		rows.push_back('{frame(K_REQ, 3'd2, 4'd2, 4'd0, 8'd0, 32'd1, 1'b0, 1'b0, 32'd101), -1,
			rsp_t'('0)});
		rows.push_back('{frame(K_REQ, 3'd3, 4'd3, 4'd5, 8'd2, 32'd7, 1'b0, 1'b0, 32'd102), -1,
			rsp_t'('0)});
		rows.push_back('{frame(K_REQ, 3'd4, 4'd3, 4'd5, 8'd3, 32'd7, 1'b0, 1'b1, 32'd102), -1,
			rsp_t'('0)});
		rows.push_back('{frame(K_REP, 3'd5, 4'd5, 4'd3, 8'd1, 32'd0, 1'b0, 1'b0, 32'd103), -1,
			rsp_t'('0)});
		rows.push_back('{frame(K_DATA, 3'd5, 4'd5, 4'd3, 8'd2, 32'd0, 1'b0, 1'b0, 32'd103), -1,
			rsp_t'('0)});
		rows.push_back('{frame(K_REQ, 3'd6, 4'd7, 4'd5, 8'd1, 32'd9, 1'b0, 1'b0, 32'd103), -1,
			rsp_t'('0)});
		rows.push_back('{frame(K_DATA, 3'd0, 4'd6, 4'd9, 8'd0, 32'd0, 1'b0, 1'b0, 32'd104), -1,
			rsp_t'('0)});
		rows.push_back('{frame(K_REQ, 3'd2, 4'd6, 4'd9, 8'd1, 32'd3, 1'b1, 1'b0, 32'd104), -1,
			rsp_t'('0)});
		rows.push_back('{frame(K_DATA, 3'd1, 4'd4, 4'd3, 8'd1, 32'd0, 1'b0, 1'b0, 32'd200), -1,
			rsp_t'('0)});
		q = frame(K_REQ, 3'd7, 4'd15, 4'd14, 8'd9, 32'hffff_ffff, 1'b0, 1'b1, 32'hffff_ffff);
		q.sender_mac = 48'hffff_ffff_ffff;
		q.origin_port = 16'hffff;
		q.target_port = 16'hffff;
		rows.push_back('{q, -1, rsp_t'('0)});
		rows.push_back('{frame(K_REP, 3'd3, 4'd8, 4'd0, 8'd1, 32'd2, 1'b0, 1'b0, 32'd300), 0,
			rsp_t'('0)});
		rows.push_back('{frame(K_REQ, 3'd2, 4'd8, 4'd2, 8'd0, 32'd4, 1'b0, 1'b0, 32'd300), -1,
			rsp_t'('0)});
		rows.push_back('{frame(K_REP, 3'd2, 4'd2, 4'd8, 8'hff, 32'd4, 1'b1, 1'b1, 32'd301), -1,
			rsp_t'('0)});

		foreach (rows[i]) begin
			route_frame(rows[i].req);
			if (rows[i].typed == 1)
				frames_due.push_back(rows[i].rsp);
			else if (rows[i].typed == -1)
				foreach (burst[j]) frames_due.push_back(burst[j]);
			send(rows[i].req);
		end
		drain();

		setup(4'd15, 16'hffff, 8'hff, 4'd1);
		random_frames(30);
		drain();
		setup(4'd3, 16'd0, 8'd0, 4'd0);
		random_frames(20);
		drain();
		setup(4'd1, 16'd4, 8'd8, 4'd15);
		calm = 1'b1;
		random_frames(50);
		calm = 1'b0;
		random_frames(30);
		drain();
		setup(4'd0, 16'd3, 8'd6, 4'd5);
		random_frames(60);
		drain();

		$display("%0d frames in, %0d items out, five register settings", frames_sent,
			frames_seen);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

// ----- sim.f -----
sv/rdisc_pkg.sv
sv/rdisc_in_if.sv
sv/rdisc_out_if.sv
sv/on_demand_route_discovery_unit.sv
dv/tb.sv
